>>> src/piecewise_bin_mapper_unit_assert.svh
// ---------------------------------------------------------------------------
// Piecewise bin mapper assertion macros
// Shared property forms for the checker, clocked on clk and held off
// while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef PIECEWISE_BIN_MAPPER_UNIT_ASSERT_SVH
`define PIECEWISE_BIN_MAPPER_UNIT_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define PBM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define PBM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> src/pbm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Piecewise bin mapper package
// Widths, codes, item types and control structs shared by the mapper files.
// ---------------------------------------------------------------------------
package pbm_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Field and datapath widths.
	localparam int DATA_W      = 32;
	localparam int ENTRY_IDX_W = 4;
	localparam int REGION_W    = 2;
	localparam int ENTRIES_W   = 5;
	localparam int FLAGS_W     = 3;
	localparam int PROD_W      = 2 * DATA_W;
	localparam int BASE_W      = PROD_W + 2;

	// Divider: two quotient bits per step.
	localparam int DIV_BITS    = 2;
	localparam int DIV_STEPS   = PROD_W / DIV_BITS;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	// Configuration port.
	localparam int ADDR_W      = 4;
	localparam int REG_IDX_W   = 2;
	localparam logic [REG_IDX_W-1:0] REG_ENTRIES = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_OPTIONS = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BELOW   = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_ABOVE   = 2'd3;

	// Option flag bit positions.
	localparam int FLAG_CLAMP_BELOW = 0;
	localparam int FLAG_CLAMP_ABOVE = 1;
	localparam int FLAG_INTERP      = 2;

	// Item operation codes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_MAP  = 1'b1;

	// Result region codes.
	localparam logic [REGION_W-1:0] REGION_BELOW   = 2'd0;
	localparam logic [REGION_W-1:0] REGION_INSIDE  = 2'd1;
	localparam logic [REGION_W-1:0] REGION_AT_LAST = 2'd2;
	localparam logic [REGION_W-1:0] REGION_ABOVE   = 2'd3;

	// Input item.
	typedef struct packed {
		logic                     opcode;
		logic [ENTRY_IDX_W-1:0]   entry_index;
		logic signed [DATA_W-1:0] entry_key;
		logic signed [DATA_W-1:0] entry_target;
		logic signed [DATA_W-1:0] sample;
	} pbm_in_t;

	// Result item.
	typedef struct packed {
		logic signed [DATA_W-1:0] mapped_value;
		logic [REGION_W-1:0]      region;
		logic [ENTRY_IDX_W-1:0]   bin_lower_index;
	} pbm_out_t;

	// Control into one table cell.
	typedef struct packed {
		logic load;
		logic shift;
	} pbm_cell_ctl_t;

	// Compare flags out of one table cell.
	typedef struct packed {
		logic ge;
		logic gt;
	} pbm_cell_cmp_t;

	// Divider status.
	typedef struct packed {
		logic done;
		logic rem_nz;
	} pbm_div_stat_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CMP,
		ST_SEARCH,
		ST_FETCH,
		ST_PICK,
		ST_PREP,
		ST_MUL,
		ST_DLD,
		ST_DIV,
		ST_ADD,
		ST_ADJ,
		ST_SAT,
		ST_DONE
	} pbm_state_t;

endpackage

>>> src/piecewise_bin_mapper_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Piecewise bin mapper unit
// Maps a Q16.16 sample through a breakpoint table held in a ring of cells,
// returning the lower target of its bin or a linear interpolation.
// ---------------------------------------------------------------------------
//
//   Channel   Direction   Handshake          Moves
//   in        sink        in_valid/in_stall  load or map item (pbm_in_t)
//   out       source      out_valid/out_stall  result item (pbm_out_t)
//   cfg       APB slave   psel/penable/pready  register write and read
//
// A load item gives no result. A map item passes through a compare state,
// the binary search and one full rotation of the sixteen-cell ring to fetch
// the bin entries. With interpolation the prepare, multiply, divider load,
// 32-step divide, add, adjust and saturate states follow.
// Reset clears the configuration registers, the result valid flag and the
// sequencer; table entries are not cleared. The result register lets a new item be taken while a result is stalled.
//
module piecewise_bin_mapper_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  pbm_pkg::pbm_in_t             in_item,
	output logic                         out_valid,
	input  logic                         out_stall,
	output pbm_pkg::pbm_out_t            out_item,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pbm_pkg::ADDR_W-1:0]   paddr,
	input  logic [pbm_pkg::DATA_W-1:0]   pwdata,
	output logic [pbm_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	localparam int D  = pbm_pkg::TABLE_DEPTH;
	localparam int IW = pbm_pkg::IDX_W;
	localparam int CW = pbm_pkg::CNT_W;
	localparam int DW = pbm_pkg::DATA_W;
	localparam int BW = pbm_pkg::BASE_W;

	// Configuration registers.
	logic [pbm_pkg::ENTRIES_W-1:0] entries_q;
	logic [pbm_pkg::FLAGS_W-1:0]   flags_q;
	logic signed [DW-1:0]          below_q;
	logic signed [DW-1:0]          above_q;
	logic                          cfg_wr;
	logic [pbm_pkg::REG_IDX_W-1:0] reg_idx;

	// Sequencer.
	pbm_pkg::pbm_state_t           state_q;
	pbm_pkg::pbm_state_t           state_d;
	logic                          in_acc;
	logic                          shift_en;
	logic                          div_start;
	logic                          out_load;

	// Search and fetch.
	logic signed [DW-1:0]          sample_q;
	logic [D-1:0]                  ge_q;
	logic [D-1:0]                  gt_q;
	logic [D-1:0]                  ge_c;
	logic [D-1:0]                  gt_c;
	logic [CW-1:0]                 lo_q;
	logic [CW-1:0]                 hi_q;
	logic [CW-1:0]                 mid_c;
	logic [CW-1:0]                 midm1_c;
	logic                          hit_c;
	logic [IW-1:0]                 last_c;
	logic [IW-1:0]                 sel_q;
	logic [IW-1:0]                 rot_q;
	logic [pbm_pkg::REGION_W-1:0]  region_q;
	logic signed [DW-1:0]          x0_q;
	logic signed [DW-1:0]          x1_q;
	logic signed [DW-1:0]          y0_q;
	logic signed [DW-1:0]          y1_q;

	// Interpolation.
	logic [DW:0]                   dv_w;
	logic [DW:0]                   dx_w;
	logic [DW:0]                   dyp_w;
	logic [DW:0]                   dyn_w;
	logic [DW-1:0]                 dv_q;
	logic [DW-1:0]                 dx_q;
	logic [DW-1:0]                 ady_q;
	logic                          neg_q;
	logic [pbm_pkg::PROD_W-1:0]    prod_q;
	logic [pbm_pkg::PROD_W-1:0]    quotient;
	pbm_pkg::pbm_div_stat_t        div_stat;
	logic [BW-1:0]                 y0_ext;
	logic [BW-1:0]                 q_ext;
	logic signed [BW-1:0]          base_q;
	logic                          base_fits;
	logic signed [DW-1:0]          res_val_q;

	// Output register.
	logic                          out_valid_q;
	pbm_pkg::pbm_out_t             out_item_q;

	// Cell ring.
	logic signed [DW-1:0]          cell_key [D];
	logic signed [DW-1:0]          cell_tgt [D];
	pbm_pkg::pbm_cell_cmp_t        cell_cmp [D];

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != pbm_pkg::ST_IDLE);

	// Configuration write and read.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[pbm_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= pbm_pkg::ENTRIES_W'(2);
			flags_q   <= '0;
			below_q   <= '0;
			above_q   <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				pbm_pkg::REG_ENTRIES: entries_q <= pwdata[pbm_pkg::ENTRIES_W-1:0];
				pbm_pkg::REG_OPTIONS: flags_q   <= pwdata[pbm_pkg::FLAGS_W-1:0];
				pbm_pkg::REG_BELOW:   below_q   <= pwdata;
				pbm_pkg::REG_ABOVE:   above_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			pbm_pkg::REG_ENTRIES: prdata = DW'(entries_q);
			pbm_pkg::REG_OPTIONS: prdata = DW'(flags_q);
			pbm_pkg::REG_BELOW:   prdata = below_q;
			pbm_pkg::REG_ABOVE:   prdata = above_q;
			default:              prdata = '0;
		endcase
	end

	// Last valid index, with the entry count held inside two and the depth.
	always_comb begin
		if (entries_q < pbm_pkg::ENTRIES_W'(2)) begin
			last_c = IW'(1);
		end else if (32'(entries_q) > 32'(D)) begin
			last_c = IW'(D - 1);
		end else begin
			last_c = IW'(entries_q - pbm_pkg::ENTRIES_W'(1));
		end
	end

	// Ring of table cells; each cell takes its neighbour's entry on a shift.
	for (genvar i = 0; i < D; i++) begin : g_cell
		pbm_pkg::pbm_cell_ctl_t ctl;

		assign ctl.load  = in_acc && (in_item.opcode == pbm_pkg::OP_LOAD) &&
			(in_item.entry_index == pbm_pkg::ENTRY_IDX_W'(i));
		assign ctl.shift = shift_en;

		pbm_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.load_key    (in_item.entry_key),
			.load_target (in_item.entry_target),
			.next_key    (cell_key[(i + 1) % D]),
			.next_target (cell_tgt[(i + 1) % D]),
			.sample      (sample_q),
			.key         (cell_key[i]),
			.target      (cell_tgt[i]),
			.cmp         (cell_cmp[i])
		);

		assign ge_c[i] = cell_cmp[i].ge;
		assign gt_c[i] = cell_cmp[i].gt;
	end

	// Binary search probe over the registered compare flags.
	always_comb begin
		mid_c   = lo_q + ((hi_q - lo_q) >> 1);
		midm1_c = mid_c - CW'(1);
		hit_c   = ge_q[midm1_c[IW-1:0]] && !ge_q[mid_c[IW-1:0]];
	end

	// Interpolation differences; the bin guarantees dv and dx fit 32 bits.
	always_comb begin
		dv_w  = {sample_q[DW-1], sample_q} - {x0_q[DW-1], x0_q};
		dx_w  = {x1_q[DW-1], x1_q} - {x0_q[DW-1], x0_q};
		dyp_w = {y1_q[DW-1], y1_q} - {y0_q[DW-1], y0_q};
		dyn_w = {y0_q[DW-1], y0_q} - {y1_q[DW-1], y1_q};
	end

	// Signed sum of the lower target and the quotient.
	assign y0_ext = {{(BW - DW){y0_q[DW-1]}}, y0_q};
	assign q_ext  = {{(BW - pbm_pkg::PROD_W){1'b0}}, quotient};
	assign base_fits = (&base_q[BW-1:DW-1]) || !(|base_q[BW-1:DW-1]);

	pbm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (dx_q),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes.
	always_comb begin
		state_d   = state_q;
		shift_en  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			pbm_pkg::ST_IDLE: begin
				if (in_acc && (in_item.opcode == pbm_pkg::OP_MAP)) begin
					state_d = pbm_pkg::ST_CMP;
				end
			end
			pbm_pkg::ST_CMP: state_d = pbm_pkg::ST_SEARCH;
			pbm_pkg::ST_SEARCH: begin
				if (!ge_q[0] || (lo_q > hi_q) || hit_c) begin
					state_d = pbm_pkg::ST_FETCH;
				end
			end
			pbm_pkg::ST_FETCH: begin
				shift_en = 1'b1;
				if (rot_q == IW'(D - 1)) begin
					state_d = pbm_pkg::ST_PICK;
				end
			end
			pbm_pkg::ST_PICK: begin
				if ((region_q == pbm_pkg::REGION_INSIDE) && flags_q[pbm_pkg::FLAG_INTERP]) begin
					state_d = pbm_pkg::ST_PREP;
				end else begin
					state_d = pbm_pkg::ST_DONE;
				end
			end
			pbm_pkg::ST_PREP: state_d = pbm_pkg::ST_MUL;
			pbm_pkg::ST_MUL:  state_d = pbm_pkg::ST_DLD;
			pbm_pkg::ST_DLD: begin
				div_start = 1'b1;
				state_d   = pbm_pkg::ST_DIV;
			end
			pbm_pkg::ST_DIV: begin
				if (div_stat.done) begin
					state_d = pbm_pkg::ST_ADD;
				end
			end
			pbm_pkg::ST_ADD: state_d = pbm_pkg::ST_ADJ;
			pbm_pkg::ST_ADJ: state_d = pbm_pkg::ST_SAT;
			pbm_pkg::ST_SAT: state_d = pbm_pkg::ST_DONE;
			pbm_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = pbm_pkg::ST_IDLE;
				end
			end
			default: state_d = pbm_pkg::ST_IDLE;
		endcase
	end

	// Datapath registers, advanced by the sequencer state.
	always_ff @(posedge clk) begin
		case (state_q)
			pbm_pkg::ST_IDLE: sample_q <= in_item.sample;
			pbm_pkg::ST_CMP: begin
				ge_q <= ge_c;
				gt_q <= gt_c;
				lo_q <= CW'(1);
				hi_q <= CW'(last_c);
			end
			pbm_pkg::ST_SEARCH: begin
				rot_q <= '0;
				if (!ge_q[0]) begin
					region_q <= pbm_pkg::REGION_BELOW;
					sel_q    <= '0;
				end else if (lo_q > hi_q) begin
					sel_q    <= last_c;
					region_q <= gt_q[last_c] ? pbm_pkg::REGION_ABOVE : pbm_pkg::REGION_AT_LAST;
				end else if (hit_c) begin
					region_q <= pbm_pkg::REGION_INSIDE;
					sel_q    <= midm1_c[IW-1:0];
				end else if (ge_q[mid_c[IW-1:0]]) begin
					lo_q <= mid_c + CW'(1);
				end else begin
					hi_q <= midm1_c;
				end
			end
			pbm_pkg::ST_FETCH: begin
				// The head cells show entries rot and rot+1 at this point.
				rot_q <= rot_q + IW'(1);
				if (rot_q == sel_q) begin
					x0_q <= cell_key[0];
					x1_q <= cell_key[1];
					y0_q <= cell_tgt[0];
					y1_q <= cell_tgt[1];
				end
			end
			pbm_pkg::ST_PICK: begin
				case (region_q)
					pbm_pkg::REGION_BELOW:
						res_val_q <= flags_q[pbm_pkg::FLAG_CLAMP_BELOW] ? y0_q : below_q;
					pbm_pkg::REGION_ABOVE:
						res_val_q <= flags_q[pbm_pkg::FLAG_CLAMP_ABOVE] ? y0_q : above_q;
					default:
						res_val_q <= y0_q;
				endcase
			end
			pbm_pkg::ST_PREP: begin
				dv_q  <= dv_w[DW-1:0];
				dx_q  <= dx_w[DW-1:0];
				neg_q <= (y1_q < y0_q);
				ady_q <= (y1_q < y0_q) ? dyn_w[DW-1:0] : dyp_w[DW-1:0];
			end
			pbm_pkg::ST_MUL: prod_q <= pbm_pkg::PROD_W'(dv_q) * pbm_pkg::PROD_W'(ady_q);
			pbm_pkg::ST_ADD: base_q <= neg_q ? (y0_ext - q_ext) : (y0_ext + q_ext);
			pbm_pkg::ST_ADJ: begin
				// Truncate toward zero when the division left a remainder.
				if (div_stat.rem_nz && !neg_q && base_q[BW-1]) begin
					base_q <= base_q + BW'(1);
				end else if (div_stat.rem_nz && neg_q && !base_q[BW-1] && (base_q != '0)) begin
					base_q <= base_q - BW'(1);
				end
			end
			pbm_pkg::ST_SAT: begin
				if (base_fits) begin
					res_val_q <= base_q[DW-1:0];
				end else if (base_q[BW-1]) begin
					res_val_q <= {1'b1, {(DW - 1){1'b0}}};
				end else begin
					res_val_q <= {1'b0, {(DW - 1){1'b1}}};
				end
			end
			default: ;
		endcase
	end

	// Result register between the sequencer and the output channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_item_q.mapped_value    <= res_val_q;
			out_item_q.region          <= region_q;
			out_item_q.bin_lower_index <= pbm_pkg::ENTRY_IDX_W'(sel_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

>>> src/pbm_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Piecewise bin mapper table cell
// Holds one breakpoint entry, compares it with the broadcast sample and
// passes its entry to the neighbouring cell while the ring rotates.
// ---------------------------------------------------------------------------
module pbm_cell (
	input  logic                              clk,
	input  pbm_pkg::pbm_cell_ctl_t            ctl,
	input  logic signed [pbm_pkg::DATA_W-1:0] load_key,
	input  logic signed [pbm_pkg::DATA_W-1:0] load_target,
	input  logic signed [pbm_pkg::DATA_W-1:0] next_key,
	input  logic signed [pbm_pkg::DATA_W-1:0] next_target,
	input  logic signed [pbm_pkg::DATA_W-1:0] sample,
	output logic signed [pbm_pkg::DATA_W-1:0] key,
	output logic signed [pbm_pkg::DATA_W-1:0] target,
	output pbm_pkg::pbm_cell_cmp_t            cmp
);

	logic signed [pbm_pkg::DATA_W-1:0] key_q;
	logic signed [pbm_pkg::DATA_W-1:0] target_q;

	// Entry storage: written by a load item, or taken from the neighbour.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q    <= load_key;
			target_q <= load_target;
		end else if (ctl.shift) begin
			key_q    <= next_key;
			target_q <= next_target;
		end
	end

	// Signed comparison of the sample against the held key.
	always_comb begin
		cmp.ge = (sample >= key_q);
		cmp.gt = (sample > key_q);
	end

	assign key    = key_q;
	assign target = target_q;

endmodule

>>> src/pbm_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Piecewise bin mapper divider
// Restoring unsigned division of the interpolation product by the bin
// width, two quotient bits per cycle.
// ---------------------------------------------------------------------------
module pbm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pbm_pkg::PROD_W-1:0]  dividend,
	input  logic [pbm_pkg::DATA_W-1:0]  divisor,
	output logic [pbm_pkg::PROD_W-1:0]  quotient,
	output pbm_pkg::pbm_div_stat_t      stat
);

	logic                          busy_q;
	logic [pbm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [pbm_pkg::DATA_W-1:0]    rem_q;
	logic [pbm_pkg::PROD_W-1:0]    quo_q;

	logic [pbm_pkg::DATA_W:0]      div_ext;
	logic [pbm_pkg::DATA_W:0]      r1;
	logic [pbm_pkg::DATA_W:0]      r1s;
	logic [pbm_pkg::DATA_W:0]      r2;
	logic [pbm_pkg::DATA_W:0]      r2s;
	logic                          b1;
	logic                          b2;

	// Two restoring steps; the partial remainder always stays below the divisor.
	always_comb begin
		div_ext = {1'b0, divisor};
		r1      = {rem_q, quo_q[pbm_pkg::PROD_W-1]};
		b1      = (r1 >= div_ext);
		r1s     = b1 ? (r1 - div_ext) : r1;
		r2      = {r1s[pbm_pkg::DATA_W-1:0], quo_q[pbm_pkg::PROD_W-2]};
		b2      = (r2 >= div_ext);
		r2s     = b2 ? (r2 - div_ext) : r2;
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + pbm_pkg::DIV_CNT_W'(1);
			if (cnt_q == pbm_pkg::DIV_CNT_W'(pbm_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient; the dividend shifts out as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= r2s[pbm_pkg::DATA_W-1:0];
			quo_q <= {quo_q[pbm_pkg::PROD_W-3:0], b1, b2};
		end
	end

	assign quotient    = quo_q;
	assign stat.done   = busy_q && (cnt_q == pbm_pkg::DIV_CNT_W'(pbm_pkg::DIV_STEPS - 1));
	assign stat.rem_nz = (rem_q != '0);

endmodule

>>> src/pbm_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Piecewise bin mapper port checker
// Watches the item channels of the mapper unit and flags illegal sequences.
// ---------------------------------------------------------------------------
`include "piecewise_bin_mapper_unit_assert.svh"

module pbm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input pbm_pkg::pbm_in_t  in_item,
	input logic              out_valid,
	input logic              out_stall,
	input pbm_pkg::pbm_out_t out_item
);

	// A map item occupies the unit, so the next item must wait.
	`PBM_ASSERT_NEXT(a_map_busy, in_valid && !in_stall && (in_item.opcode == pbm_pkg::OP_MAP), in_stall, "map item did not block the input")

	// A load item finishes at once and leaves the input open.
	`PBM_ASSERT_NEXT(a_load_free, in_valid && !in_stall && (in_item.opcode == pbm_pkg::OP_LOAD), !in_stall, "load item blocked the input")

	// A stalled result item stays in place.
	`PBM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result item changed")

	// Results below the range always report the first entry.
	`PBM_ASSERT_NOW(a_below_idx, out_valid && (out_item.region == pbm_pkg::REGION_BELOW), out_item.bin_lower_index == '0, "below-range result with nonzero index")

endmodule

bind piecewise_bin_mapper_unit pbm_checker u_pbm_checker (.*);
